/* hdl/wildcard_byte_pattern_scanner_unit_defines.svh */
// Assertion macros shared by the checker.
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_UNIT_DEFINES_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define WBPS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wbps check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define WBPS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wbps check failed");

`endif

/* hdl/wbps_pkg.sv */
package wbps_pkg;

	localparam int PATTERN_MAX = 256;
	localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int LEN_W = 9;
	localparam int LEN_EFF_W = $clog2(PATTERN_MAX + 1);
	localparam int SEL_W = ((IDX_W > 8) ? IDX_W : 8) + 1;
	localparam int CNT_W = 32;
	localparam int GROUP = 16;
	localparam int GROUPS = (PATTERN_MAX + GROUP - 1) / GROUP;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_BYTE = 1'b1;

	localparam logic REG_PATTERN_LENGTH = 1'b0;

	typedef struct packed {
		logic       shift;
		logic       rotate;
		logic       load;
		logic [7:0] wr_byte;
		logic       wr_care;
	} cell_ctrl_t;

	typedef struct packed {
		logic             empty;
		logic             enough;
		logic             last;
		logic [CNT_W-1:0] start;
	} meta_t;

endpackage

/* hdl/wbps_cell.sv */
module wbps_cell (
	input  logic                  clk,
	input  wbps_pkg::cell_ctrl_t  ctrl,
	input  logic                  sel,
	input  logic                  active,
	input  logic [7:0]            data_in,
	output logic [7:0]            data_out,
	input  logic [7:0]            pat_in,
	input  logic                  care_in,
	output logic [7:0]            pat_out,
	output logic                  care_out,
	output logic                  mism
);

	logic [7:0] data_q;
	logic [7:0] pat_q;
	logic       care_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			data_q <= data_in;
		end
		if (ctrl.rotate) begin
			pat_q  <= pat_in;
			care_q <= care_in;
		end else if (ctrl.load && sel) begin
			pat_q  <= ctrl.wr_byte;
			care_q <= ctrl.wr_care;
		end
	end

	assign data_out = data_q;
	assign pat_out  = pat_q;
	assign care_out = care_q;
	assign mism     = active && care_q && (data_in != pat_q);

endmodule

/* hdl/wbps_verdict.sv */
module wbps_verdict (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  take,
	input  logic [wbps_pkg::PATTERN_MAX-1:0]      mism,
	input  wbps_pkg::meta_t                       meta,
	output logic                                  slot_free,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  found,
	output logic [wbps_pkg::CNT_W-1:0]            match_offset
);

	logic                               v1_q;
	logic [wbps_pkg::PATTERN_MAX-1:0]   mism_s1;
	wbps_pkg::meta_t                    meta_s1;
	logic                               v2_q;
	logic [wbps_pkg::GROUPS-1:0]        grp_s2;
	logic [wbps_pkg::GROUPS-1:0]        grp_d;
	wbps_pkg::meta_t                    meta_s2;
	logic                               rep_q;
	logic                               out_valid_q;
	logic                               found_q;
	logic [wbps_pkg::CNT_W-1:0]         offset_q;
	logic                               hit2;
	logic                               produce2;
	logic                               out_free;
	logic                               adv1;
	logic                               adv2;

	always_comb begin
		grp_d = '0;
		for (int g = 0; g < wbps_pkg::GROUPS; g++) begin
			for (int b = 0; b < wbps_pkg::GROUP; b++) begin
				if (g * wbps_pkg::GROUP + b < wbps_pkg::PATTERN_MAX) begin
					grp_d[g] = grp_d[g] | mism_s1[g * wbps_pkg::GROUP + b];
				end
			end
		end
	end

	assign hit2      = meta_s2.empty || (meta_s2.enough && !(|grp_s2));
	assign produce2  = !rep_q && (hit2 || meta_s2.last);
	assign out_free  = !out_valid_q || out_ready;
	assign adv2      = v2_q && (!produce2 || out_free);
	assign adv1      = v1_q && (!v2_q || adv2);
	assign slot_free = !v1_q || adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			rep_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				v1_q <= 1'b1;
			end else if (adv1) begin
				v1_q <= 1'b0;
			end
			if (adv1) begin
				v2_q <= 1'b1;
			end else if (adv2) begin
				v2_q <= 1'b0;
			end
			if (adv2) begin
				rep_q <= meta_s2.last ? 1'b0 : (rep_q || hit2);
			end
			if (adv2 && produce2) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			mism_s1 <= mism;
			meta_s1 <= meta;
		end
		if (adv1) begin
			grp_s2  <= grp_d;
			meta_s2 <= meta_s1;
		end
		if (adv2 && produce2) begin
			found_q  <= hit2;
			offset_q <= hit2 ? meta_s2.start : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign found        = found_q;
	assign match_offset = offset_q;

endmodule

/* hdl/wildcard_byte_pattern_scanner_unit.sv */
// Wildcard byte pattern scanner.
// Config: write pattern_length (9 bits) at byte address 0 over the APB port;
// pready is always high and reads return the stored length.
// Input channel (in_valid/in_ready): req_type 0 loads pattern entry
// entry_index with pattern_byte and care_bit; req_type 1 presents data_byte
// of the region, last_byte marking its final byte.
// Output channel (out_valid/out_ready): found with match_offset at the first
// match of the region, or found 0 with offset 0 at the last byte.
// Throughput: one transaction per cycle while in_ready is high. In the accepting
// cycle the new byte and the chained bytes are compared against the pattern cells;
// the verdict then passes the mismatch register, group OR register, output register.
// A length write that moves the pattern alignment rotates the cell ring one
// position per cycle; in_ready stays low until it is aligned (up to 255 positions).
// Reset clears the length, the byte counter and all valid flags; pattern
// cells hold unknown data until loaded. When out_ready is low the result
// holds; bytes keep flowing until a second result waits behind it, then one
// more byte is taken and in_ready drops.
module wildcard_byte_pattern_scanner_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [wbps_pkg::ADDR_W-1:0]    paddr,
	input  logic [wbps_pkg::DATA_W-1:0]    pwdata,
	output logic [wbps_pkg::DATA_W-1:0]    prdata,
	output logic                           pready,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           req_type,
	input  logic [7:0]                     entry_index,
	input  logic [7:0]                     pattern_byte,
	input  logic                           care_bit,
	input  logic [7:0]                     data_byte,
	input  logic                           last_byte,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           found,
	output logic [wbps_pkg::CNT_W-1:0]     match_offset
);

	localparam int PM = wbps_pkg::PATTERN_MAX;

	logic [wbps_pkg::LEN_W-1:0]      len_q;
	logic [wbps_pkg::LEN_EFF_W-1:0]  len_eff;
	logic [wbps_pkg::IDX_W-1:0]      key_tgt;
	logic [wbps_pkg::IDX_W-1:0]      align_q;
	logic                            aligned;
	logic [wbps_pkg::CNT_W-1:0]      seen_q;
	logic [wbps_pkg::CNT_W-1:0]      seen_next;
	logic                            take;
	logic                            slot_free;
	logic                            cfg_wr;
	logic [wbps_pkg::SEL_W-1:0]      idx_ext;
	logic [wbps_pkg::SEL_W-1:0]      key_ext;
	logic [wbps_pkg::SEL_W-1:0]      wsum;
	logic                            load_ok;
	logic [wbps_pkg::IDX_W-1:0]      wcell;
	wbps_pkg::cell_ctrl_t            ctrl;
	wbps_pkg::meta_t                 meta;
	logic [7:0]                      data_w [0:PM];
	logic [7:0]                      pat_w  [0:PM-1];
	logic [PM-1:0]                   care_w;
	logic [PM-1:0]                   mism;
	logic [PM-1:0]                   active;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[wbps_pkg::ADDR_W-1:2] == (wbps_pkg::ADDR_W-2)'(wbps_pkg::REG_PATTERN_LENGTH));

	always_comb begin
		prdata = '0;
		if (paddr[wbps_pkg::ADDR_W-1:2] == (wbps_pkg::ADDR_W-2)'(wbps_pkg::REG_PATTERN_LENGTH)) begin
			prdata = wbps_pkg::DATA_W'(len_q);
		end
	end

	always_comb begin
		if (32'(len_q) > 32'(PM)) begin
			len_eff = wbps_pkg::LEN_EFF_W'(PM);
		end else begin
			len_eff = wbps_pkg::LEN_EFF_W'(len_q);
		end
		if (len_eff == '0) begin
			key_tgt = wbps_pkg::IDX_W'(PM - 1);
		end else begin
			key_tgt = wbps_pkg::IDX_W'(len_eff - wbps_pkg::LEN_EFF_W'(1));
		end
	end

	assign aligned  = (align_q == key_tgt);
	assign in_ready = aligned && slot_free;
	assign take     = in_valid && in_ready && (req_type == wbps_pkg::REQ_BYTE);

	assign idx_ext = wbps_pkg::SEL_W'(entry_index);
	assign key_ext = wbps_pkg::SEL_W'(align_q);
	assign load_ok = idx_ext < wbps_pkg::SEL_W'(PM);
	assign wsum    = (key_ext >= idx_ext) ? (key_ext - idx_ext)
		: (key_ext + wbps_pkg::SEL_W'(PM) - idx_ext);
	assign wcell   = wsum[wbps_pkg::IDX_W-1:0];

	always_comb begin
		ctrl.shift   = take;
		ctrl.rotate  = !aligned;
		ctrl.load    = in_valid && in_ready && (req_type == wbps_pkg::REQ_LOAD) && load_ok;
		ctrl.wr_byte = pattern_byte;
		ctrl.wr_care = care_bit;
	end

	assign seen_next = (&seen_q) ? seen_q : (seen_q + wbps_pkg::CNT_W'(1));

	always_comb begin
		meta.empty  = (len_eff == '0);
		meta.enough = seen_next >= wbps_pkg::CNT_W'(len_eff);
		meta.last   = last_byte;
		meta.start  = meta.empty ? '0 : (seen_next - wbps_pkg::CNT_W'(len_eff));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			align_q <= wbps_pkg::IDX_W'(PM - 1);
			seen_q  <= '0;
		end else begin
			if (cfg_wr) begin
				len_q <= pwdata[wbps_pkg::LEN_W-1:0];
			end
			if (!aligned) begin
				align_q <= (align_q == wbps_pkg::IDX_W'(PM - 1)) ? '0
					: (align_q + wbps_pkg::IDX_W'(1));
			end
			if (take) begin
				seen_q <= last_byte ? '0 : seen_next;
			end
		end
	end

	assign data_w[0] = data_byte;

	for (genvar c = 0; c < PM; c++) begin : g_cell
		localparam int PREV = (c == 0) ? PM - 1 : c - 1;

		assign active[c] = (wbps_pkg::LEN_EFF_W + 1)'(c) < (wbps_pkg::LEN_EFF_W + 1)'(len_eff);

		wbps_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.sel      (wcell == wbps_pkg::IDX_W'(c)),
			.active   (active[c]),
			.data_in  (data_w[c]),
			.data_out (data_w[c+1]),
			.pat_in   (pat_w[PREV]),
			.care_in  (care_w[PREV]),
			.pat_out  (pat_w[c]),
			.care_out (care_w[c]),
			.mism     (mism[c])
		);
	end

	wbps_verdict u_verdict (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.mism         (mism),
		.meta         (meta),
		.slot_free    (slot_free),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.found        (found),
		.match_offset (match_offset)
	);

endmodule

/* hdl/wbps_checker.sv */
`include "wildcard_byte_pattern_scanner_unit_defines.svh"

module wbps_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           psel,
	input logic                           penable,
	input logic                           pwrite,
	input logic [wbps_pkg::ADDR_W-1:0]    paddr,
	input logic [wbps_pkg::DATA_W-1:0]    pwdata,
	input logic [wbps_pkg::DATA_W-1:0]    prdata,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic                           found,
	input logic [wbps_pkg::CNT_W-1:0]     match_offset
);

	`WBPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(found) && $stable(match_offset))

	`WBPS_ASSERT_NOW(a_miss_zero, out_valid && !found, match_offset == '0)

	`WBPS_ASSERT_NEXT(a_len_readback,
		psel && penable && pwrite && (paddr[wbps_pkg::ADDR_W-1:2] == '0),
		!(psel && !pwrite && (paddr[wbps_pkg::ADDR_W-1:2] == '0))
		|| (prdata == wbps_pkg::DATA_W'($past(pwdata[wbps_pkg::LEN_W-1:0]))))

endmodule

bind wildcard_byte_pattern_scanner_unit wbps_checker u_wbps_checker (.*);

/* test/wbps_scan_checker.sv */
`timescale 1ns / 1ps

module wbps_scan_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [wbps_pkg::ADDR_W-1:0]  paddr,
	input  logic [wbps_pkg::DATA_W-1:0]  pwdata,
	input  logic                         pready,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic                         req_type,
	input  logic [7:0]                   entry_index,
	input  logic [7:0]                   pattern_byte,
	input  logic                         care_bit,
	input  logic [7:0]                   data_byte,
	input  logic                         last_byte,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic                         found,
	input  logic [wbps_pkg::CNT_W-1:0]   match_offset,
	output int                           mismatches,
	output int                           outstanding
);
	import wbps_pkg::*;

	localparam logic [ADDR_W-1:0] LEN_ADDR = ADDR_W'(4 * REG_PATTERN_LENGTH);
	localparam int HIST_DEPTH = PATTERN_MAX - 1;

	typedef struct packed {
		logic             found;
		logic [CNT_W-1:0] offset;
	} verdict_t;

	verdict_t         awaited_verdicts[$];
	logic [7:0]       recent[HIST_DEPTH];
	logic [7:0]       sig_byte[PATTERN_MAX];
	logic             sig_care[PATTERN_MAX];
	logic [CNT_W-1:0] seen;
	logic             reported;
	logic [LEN_W-1:0] sig_len;

	function automatic bit window_hit(int unsigned len, logic [7:0] cur);
		logic [7:0] b;
		int unsigned age;
		for (int unsigned j = 0; j < len; j++) begin
			age = len - 1 - j;
			b = (age == 0) ? cur : recent[age - 1];
			if (sig_care[j] && b != sig_byte[j])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic scan_byte(logic [7:0] cur, logic last);
		int unsigned eff;
		logic [CNT_W-1:0] nxt;
		verdict_t v;
		eff = (sig_len > PATTERN_MAX) ? PATTERN_MAX : sig_len;
		nxt = (seen == '1) ? seen : seen + 1'b1;
		if (!reported) begin
			if (eff == 0 || (nxt >= eff && window_hit(eff, cur))) begin
				reported = 1'b1;
				v.found = 1'b1;
				v.offset = (eff == 0) ? '0 : nxt - CNT_W'(eff);
				awaited_verdicts.push_back(v);
			end else if (last) begin
				v = '0;
				awaited_verdicts.push_back(v);
			end
		end
		for (int k = HIST_DEPTH - 1; k > 0; k--)
			recent[k] = recent[k - 1];
		recent[0] = cur;
		seen = last ? '0 : nxt;
		if (last)
			reported = 1'b0;
	endtask

	task automatic note_mismatch(string what, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s mismatch: expected %0h, got %0h", $realtime, what, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		verdict_t v;
		if (!arst_n) begin
			awaited_verdicts.delete();
			for (int k = 0; k < HIST_DEPTH; k++)
				recent[k] = '0;
			seen = '0;
			reported = 1'b0;
			sig_len = '0;
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (awaited_verdicts.size() == 0) begin
					note_mismatch("unexpected transaction", '0, {31'd0, found});
				end else begin
					v = awaited_verdicts.pop_front();
					if (found !== v.found)
						note_mismatch("found", {31'd0, v.found}, {31'd0, found});
					if (match_offset !== v.offset)
						note_mismatch("match_offset", v.offset, match_offset);
				end
			end
			if (psel && penable && pwrite && pready && paddr == LEN_ADDR)
				sig_len = pwdata[LEN_W-1:0];
			if (in_valid && in_ready) begin
				if (req_type == REQ_LOAD) begin
					sig_byte[entry_index] = pattern_byte;
					sig_care[entry_index] = care_bit;
				end else begin
					scan_byte(data_byte, last_byte);
				end
			end
			outstanding = awaited_verdicts.size();
		end
	end

endmodule

/* test/wildcard_byte_pattern_scanner_unit_tb.sv */
`timescale 1ns / 1ps

module wildcard_byte_pattern_scanner_unit_tb;
	import wbps_pkg::*;

	localparam logic [ADDR_W-1:0] LEN_ADDR = ADDR_W'(4 * REG_PATTERN_LENGTH);

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid;
	logic              in_ready;
	logic              req_type;
	logic [7:0]        entry_index;
	logic [7:0]        pattern_byte;
	logic              care_bit;
	logic [7:0]        data_byte;
	logic              last_byte;
	logic              out_valid;
	logic              out_ready;
	logic              found;
	logic [CNT_W-1:0]  match_offset;

	int mismatches;
	int outstanding;

	bit         calm = 1'b0;
	int         hold_cycles = 0;
	int         items_sent = 0;
	int         cur_len = 0;
	logic [7:0] pat_copy[PATTERN_MAX];
	logic       care_copy[PATTERN_MAX];
	bit         loaded[PATTERN_MAX];

	wildcard_byte_pattern_scanner_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.entry_index  (entry_index),
		.pattern_byte (pattern_byte),
		.care_bit     (care_bit),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.found        (found),
		.match_offset (match_offset)
	);

	wbps_scan_checker scan_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.entry_index  (entry_index),
		.pattern_byte (pattern_byte),
		.care_bit     (care_bit),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.found        (found),
		.match_offset (match_offset),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#4_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= calm || $urandom_range(0, 99) >= 25;
			end
		end
	end

	task automatic push_item(logic rt, logic [7:0] idx, logic [7:0] pb, logic cb,
			logic [7:0] db, logic lb);
		if (!calm && $urandom_range(0, 99) < 25) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 1)) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		req_type <= rt;
		entry_index <= idx;
		pattern_byte <= pb;
		care_bit <= cb;
		data_byte <= db;
		last_byte <= lb;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic load_entry(logic [7:0] idx, logic [7:0] b, logic c);
		push_item(REQ_LOAD, idx, b, c, 8'($urandom()), 1'($urandom()));
		pat_copy[idx] = b;
		care_copy[idx] = c;
		loaded[idx] = 1'b1;
	endtask

	task automatic send_byte(logic [7:0] b, logic last);
		push_item(REQ_BYTE, 8'($urandom()), 8'($urandom()), 1'($urandom()), b, last);
	endtask

	task automatic set_length(logic [LEN_W-1:0] val);
		logic [DATA_W-1:0] wdata;
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (6) @(negedge clk);
		wdata = $urandom();
		wdata[LEN_W-1:0] = val;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= LEN_ADDR;
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		cur_len = (val > PATTERN_MAX) ? PATTERN_MAX : val;
	endtask

	task automatic load_upto(int n, int redo_pct);
		logic [7:0] b;
		for (int i = 0; i < n; i++) begin
			if (!loaded[i] || $urandom_range(0, 99) < redo_pct) begin
				b = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom());
				load_entry(8'(i), b, $urandom_range(0, 99) < 75);
			end
		end
	endtask

	task automatic send_region(int nbytes, int embed_at, bit narrow);
		logic [7:0] b;
		for (int p = 0; p < nbytes; p++) begin
			if (embed_at >= 0 && p >= embed_at && p < embed_at + cur_len
					&& care_copy[p - embed_at])
				b = pat_copy[p - embed_at];
			else
				b = narrow ? 8'($urandom_range(0, 3)) : 8'($urandom());
			if (!calm && $urandom_range(0, 99) < 3)
				load_entry(8'($urandom()), 8'($urandom()), 1'($urandom()));
			send_byte(b, p == nbytes - 1);
		end
	endtask

	initial begin
		int r;
		int nb;
		int embed;
		int guard;
		logic [LEN_W-1:0] len_val;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		req_type = REQ_LOAD;
		entry_index = '0;
		pattern_byte = '0;
		care_bit = 1'b0;
		data_byte = '0;
		last_byte = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty pattern, match on the first byte of each region
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'h5A, 1'b1);
		load_entry(8'd0, 8'h00, 1'b1);
		load_entry(8'd1, 8'hAA, 1'b0);
		load_entry(8'd2, 8'hFF, 1'b1);
		load_entry(8'd255, 8'hFF, 1'b1);
		set_length(LEN_W'(3));
		send_byte(8'h00, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h37, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h12, 1'b1);
		send_byte(8'h11, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h01, 1'b0);
		send_byte(8'h02, 1'b0);
		send_byte(8'h03, 1'b1);
		// change the length inside a region
		send_byte(8'h00, 1'b0);
		set_length(LEN_W'(1));
		send_byte(8'h00, 1'b0);
		send_byte(8'h01, 1'b1);

		for (int phase = 0; items_sent < 700 || phase < 5; phase++) begin
			calm = (phase == 2);
			if (phase == 3) begin
				len_val = '1;
			end else if (phase == 4) begin
				len_val = '0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 10)
					len_val = '0;
				else if (r < 75)
					len_val = LEN_W'($urandom_range(1, 6));
				else
					len_val = LEN_W'($urandom_range(7, 40));
			end
			set_length(len_val);
			load_upto(cur_len, (phase == 3) ? 0 : 20);
			if (phase == 4) begin
				// hold the output while single-byte regions keep coming
				hold_cycles = 400;
				repeat (60) send_byte(8'($urandom()), 1'b1);
			end else if (cur_len >= 200) begin
				send_region(cur_len + 2, $urandom_range(0, 2), 1'b0);
				if (phase == 3) begin
					set_length(LEN_W'(PATTERN_MAX));
					send_region(40, -1, 1'b0);
				end
			end else begin
				repeat ($urandom_range(3, 8)) begin
					nb = $urandom_range(1, cur_len + 12);
					if ($urandom_range(0, 99) < 65 && nb >= cur_len)
						embed = $urandom_range(0, nb - cur_len);
					else
						embed = -1;
					send_region(nb, embed, 1'($urandom_range(0, 1)));
				end
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		guard = 0;
		while (outstanding != 0 && guard < 100000) begin
			@(negedge clk);
			guard++;
		end
		repeat (8) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
